### hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [15:0] KEY_LIMIT = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [15:0] key;
    logic [7:0]  owner;
  } cell_cmd_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [7:0]  owner;
  } entry_t;

endpackage
`default_nettype wire

### hdl/spq_cell.sv
// One slot of the sorted store: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    left_entry,
  input  logic      left_ins,
  input  logic      left_seen,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      ins_flag,
  output logic      seen,
  output logic      first_hit
);

  logic        valid_r, valid_nxt;
  logic [15:0] key_r, key_nxt;
  logic [7:0]  owner_r, owner_nxt;
  logic        match;

  assign entry     = '{valid: valid_r, key: key_r, owner: owner_r};
  assign match     = valid_r && (owner_r == cmd.owner);
  assign ins_flag  = !valid_r || (key_r > cmd.key);
  assign seen      = left_seen || match;
  assign first_hit = match && !left_seen;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    owner_nxt = owner_r;
    case (cmd.op)
      OP_INSERT: begin
        if (ins_flag) begin
          if (left_ins) begin
            valid_nxt = left_entry.valid;
            key_nxt   = left_entry.key;
            owner_nxt = left_entry.owner;
          end else begin
            valid_nxt = 1'b1;
            key_nxt   = cmd.key;
            owner_nxt = cmd.owner;
          end
        end
      end
      OP_POP: begin
        valid_nxt = right_entry.valid;
        key_nxt   = right_entry.key;
        owner_nxt = right_entry.owner;
      end
      OP_REMOVE: begin
        if (seen) begin
          valid_nxt = right_entry.valid;
          key_nxt   = right_entry.key;
          owner_nxt = right_entry.owner;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    owner_r <= owner_nxt;
  end

endmodule
`default_nettype wire

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: row of slot cells and result register.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_kind, in_key, in_owner
//   out     | output    | out_valid, out_stall, out_status, out_key, out_owner, out_count
//
// One operation per cycle unless the input is stalled: every cell compares against
// the request in parallel and shifts by one slot, so no operation needs a second pass.
// The result is registered in the output register and appears in the cycle after the input transfer.
// Synchronous reset empties the queue; only the valid bits, the count and out_valid are cleared.
// A held result stalls the input; a new transfer is taken in the cycle it leaves.
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_key,
  input  logic [7:0]  in_owner,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_key,
  output logic [7:0]  out_owner,
  output logic [4:0]  out_count
);

  entry_t    entries   [CAPACITY];
  entry_t    left_e    [CAPACITY];
  entry_t    right_e   [CAPACITY];
  logic      left_ins  [CAPACITY];
  logic      left_seen [CAPACITY];
  logic      ins       [CAPACITY];
  logic      seen      [CAPACITY];
  logic      hit       [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;

  cell_cmd_t  cmd;
  logic       accept;
  logic       full, empty, found, reject;
  entry_t     hit_entry;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [15:0]      rkey_r, rkey_nxt;
  logic [7:0]       rowner_r, rowner_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign found  = seen[CAPACITY-1];
  assign reject = full || (in_key >= KEY_LIMIT);

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) hit_entry = hit_entry | entries[i];
    end
  end

  always_comb begin
    cmd.key   = in_key;
    cmd.owner = in_owner;
    cmd.op    = OP_HOLD;
    if (accept) begin
      case (kind_t'(in_kind))
        KIND_INSERT: if (!reject) cmd.op = OP_INSERT;
        KIND_POP:    if (!empty) cmd.op = OP_POP;
        KIND_REMOVE: if (found) cmd.op = OP_REMOVE;
        default:     cmd.op = OP_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid_vec[i] = entries[i].valid;
    if (i == 0) begin : g_first
      assign left_e[i]    = '0;
      assign left_ins[i]  = 1'b0;
      assign left_seen[i] = 1'b0;
    end else begin : g_chain
      assign left_e[i]    = entries[i-1];
      assign left_ins[i]  = ins[i-1];
      assign left_seen[i] = seen[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e[i] = '0;
    end else begin : g_next
      assign right_e[i] = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_e[i]),
      .left_ins    (left_ins[i]),
      .left_seen   (left_seen[i]),
      .right_entry (right_e[i]),
      .entry       (entries[i]),
      .ins_flag    (ins[i]),
      .seen        (seen[i]),
      .first_hit   (hit[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    rkey_nxt      = rkey_r;
    rowner_nxt    = rowner_r;
    count_nxt     = count_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      rkey_nxt      = '0;
      rowner_nxt    = '0;
      case (kind_t'(in_kind))
        KIND_INSERT: begin
          if (reject) begin
            status_nxt = ST_REJECT;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        KIND_POP: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rkey_nxt   = entries[0].key;
            rowner_nxt = entries[0].owner;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        KIND_REMOVE: begin
          if (found) begin
            rkey_nxt   = hit_entry.key;
            rowner_nxt = hit_entry.owner;
            count_nxt  = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rkey_r   <= rkey_nxt;
    rowner_r <= rowner_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_key    = rkey_r;
  assign out_owner  = rowner_r;
  assign out_count  = 5'(count_r);

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("entry count disagrees with occupied slots");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied slots are not packed at the head");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_INSERT && !reject) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted insert did not grow the queue");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_REMOVE && found) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("matched remove did not shrink the queue");

endmodule
`default_nettype wire

### tb/sv/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: shadow predictor, scoreboard, drivers.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  typedef struct {
    status_t     status;
    logic [15:0] key;
    logic [7:0]  owner;
    logic [4:0]  count;
  } queue_reply_t;

  class queue_scoreboard;
    logic [15:0]  shadow_key [CAPACITY];
    logic [7:0]   shadow_owner [CAPACITY];
    int           shadow_depth;
    queue_reply_t owed_replies[$];
    int           errors;
    int           replies_seen;
    int           n_insert;
    int           n_reject;
    int           n_taken_out;
    int           n_empty;
    int           n_notfound;
    int           n_full_seen;

    function new();
      shadow_depth = 0;
      errors = 0;
      replies_seen = 0;
      n_insert = 0;
      n_reject = 0;
      n_taken_out = 0;
      n_empty = 0;
      n_notfound = 0;
      n_full_seen = 0;
    endfunction

    task report(string msg);
      if (errors < 100) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    function void drop_slot(int pos);
      int i;
      for (i = pos; i + 1 < shadow_depth; i++) begin
        shadow_key[i]   = shadow_key[i + 1];
        shadow_owner[i] = shadow_owner[i + 1];
      end
      shadow_depth--;
    endfunction

    function void take_request(logic [1:0] kind, logic [15:0] key, logic [7:0] owner);
      queue_reply_t want;
      int pos;
      int i;
      want.status = ST_OK;
      want.key = '0;
      want.owner = '0;
      case (kind)
        KIND_INSERT: begin
          if (shadow_depth >= CAPACITY || key >= KEY_LIMIT) begin
            want.status = ST_REJECT;
            n_reject++;
          end else begin
            pos = 0;
            while (pos < shadow_depth && shadow_key[pos] <= key) pos++;
            for (i = shadow_depth; i > pos; i--) begin
              shadow_key[i]   = shadow_key[i - 1];
              shadow_owner[i] = shadow_owner[i - 1];
            end
            shadow_key[pos]   = key;
            shadow_owner[pos] = owner;
            shadow_depth++;
            n_insert++;
            if (shadow_depth == CAPACITY) n_full_seen++;
          end
        end
        KIND_POP: begin
          if (shadow_depth == 0) begin
            want.status = ST_EMPTY;
            n_empty++;
          end else begin
            want.key   = shadow_key[0];
            want.owner = shadow_owner[0];
            drop_slot(0);
            n_taken_out++;
          end
        end
        KIND_REMOVE: begin
          pos = -1;
          for (i = 0; i < shadow_depth; i++) begin
            if (pos < 0 && shadow_owner[i] == owner) pos = i;
          end
          if (pos < 0) begin
            want.status = ST_NOTFOUND;
            n_notfound++;
          end else begin
            want.key   = shadow_key[pos];
            want.owner = shadow_owner[pos];
            drop_slot(pos);
            n_taken_out++;
          end
        end
        default: ;
      endcase
      want.count = 5'(shadow_depth);
      owed_replies.push_back(want);
    endfunction

    task check_reply(logic [1:0] st, logic [15:0] key, logic [7:0] owner, logic [4:0] count);
      queue_reply_t want;
      if (owed_replies.size() == 0) begin
        report($sformatf("result with nothing pending (status %0d key %0h owner %0h)",
                         st, key, owner));
      end else begin
        want = owed_replies.pop_front();
        replies_seen++;
        if (st !== want.status)
          report($sformatf("status got %0d expected %0d", st, want.status));
        if (key !== want.key)
          report($sformatf("out_key got %0h expected %0h", key, want.key));
        if (owner !== want.owner)
          report($sformatf("out_owner got %0h expected %0h", owner, want.owner));
        if (count !== want.count)
          report($sformatf("out_count got %0d expected %0d", count, want.count));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [15:0] in_key;
  logic [7:0]  in_owner;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_key;
  logic [7:0]  out_owner;
  logic [4:0]  out_count;

  queue_scoreboard sb = new();
  int              accepted_in = 0;

  sorted_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_key     (in_key),
    .in_owner   (in_owner),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_key    (out_key),
    .out_owner  (out_owner),
    .out_count  (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_sorted_priority_queue: errors");
    $finish;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_reply(out_status, out_key, out_owner, out_count);
      if (in_valid && !in_stall) begin
        sb.take_request(in_kind, in_key, in_owner);
        accepted_in++;
      end
    end
  end

  task automatic offer(logic [1:0] kind, logic [15:0] key, logic [7:0] owner, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_owner <= owner;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // receiver: random stalls, one long hold-off to back the queue up
  initial begin
    int  stall_len;
    int  run_len;
    bit  held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && accepted_in >= 40) begin
        held_off = 1'b1;
        stall_len = 90;
      end else begin
        stall_len = pick_pause();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
    end
  end

  initial begin
    int          i;
    int          gap;
    int          fill_bias;
    int          roll;
    kind_t       kind;
    logic [15:0] key;
    logic [7:0]  owner;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_kind  <= KIND_NONE;
    in_key   <= '0;
    in_owner <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(KIND_POP,    16'h0000, 8'h00, pick_pause());
    offer(KIND_REMOVE, 16'h0000, 8'h00, pick_pause());
    offer(KIND_NONE,   16'hFFFF, 8'hFF, pick_pause());
    offer(KIND_INSERT, 16'hFFFF, 8'hFF, pick_pause());
    offer(KIND_INSERT, 16'hFFFE, 8'hFF, pick_pause());
    offer(KIND_INSERT, 16'h0000, 8'h00, pick_pause());
    offer(KIND_INSERT, 16'h1234, 8'hAA, pick_pause());
    offer(KIND_INSERT, 16'h1234, 8'h55, pick_pause());
    offer(KIND_INSERT, 16'h0000, 8'h01, pick_pause());
    offer(KIND_REMOVE, 16'h0000, 8'h55, pick_pause());
    offer(KIND_REMOVE, 16'h0000, 8'h77, pick_pause());
    offer(KIND_POP,    16'h0000, 8'h00, pick_pause());
    for (i = 0; i < 13; i++) begin
      owner = (i % 3 == 0) ? 8'h3C : 8'(i + 16);
      offer(KIND_INSERT, 16'((i % 5) * 1000), owner, pick_pause());
    end
    offer(KIND_INSERT, 16'h0001, 8'h02, pick_pause());
    offer(KIND_REMOVE, 16'h0000, 8'h3C, pick_pause());

    fill_bias = 50;
    for (i = 0; i < 1320; i++) begin
      if (i % 110 == 0) fill_bias = $urandom_range(15, 85);
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = KIND_NONE;
      else if ($urandom_range(0, 99) < fill_bias) kind = KIND_INSERT;
      else if ($urandom_range(0, 1) == 0) kind = KIND_POP;
      else kind = KIND_REMOVE;
      roll = $urandom_range(0, 19);
      if (roll == 0) key = 16'hFFFF;
      else if (roll == 1) key = 16'hFFFE;
      else if (roll < 7) key = 16'($urandom_range(0, 7));
      else key = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < 75) owner = 8'($urandom_range(0, 15));
      else owner = 8'($urandom_range(0, 255));
      gap = (i % 300 < 60) ? 0 : pick_pause();
      offer(kind, key, owner, gap);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d transfers, %0d results: %0d inserts, %0d rejected, %0d taken out",
             accepted_in, sb.replies_seen, sb.n_insert, sb.n_reject, sb.n_taken_out);
    $display("queue full %0d times, %0d pops on empty, %0d removes of an absent owner",
             sb.n_full_seen, sb.n_empty, sb.n_notfound);
    if (sb.errors == 0) begin
      $display("tb_sorted_priority_queue: clean");
    end else begin
      $display("tb_sorted_priority_queue: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
